@@ src/sle_pkg.sv @@
// shared types and constants for the serial console line editor
`default_nettype none
package sle_pkg;

  localparam int LINE_SIZE   = 32;
  localparam int ADDR_W      = $clog2(LINE_SIZE);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_ECHO,
    OP_BS,
    OP_CR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [7:0]         data;
    logic [ADDR_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         data;
  } line_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ECHO,
    BK_RD,
    BK_LINE
  } back_state_t;

endpackage
`default_nettype wire

@@ src/sle_if.sv @@
// handshake channels for received bytes and result items
`default_nettype none
interface sle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

@@ src/serial_console_line_editor.sv @@
// top level of the serial console line editor
// usage:
//   rx channel: one received byte per request (valid/ready, rx_byte)
//   res channel: result requests with kind (0 echo, 1 line byte, 2 empty line),
//     value and last, which marks the final result caused by one received byte
// flow:
//   a plain byte, with the back end idle, passes the command queue, the back end's
//   command register and the output register before its echo shows; a backspace
//   gives three echo results; a carriage return gives three echo results, then
//   each stored byte in turn, each through a read state for the line store's
//   registered read and a state that loads the output register, or the empty
//   line marker if the line is empty
//   the command queue holds two requests, so bytes keep arriving while echoes
//   drain; while a line is handed over no new byte is taken; line feed,
//   backspace on an empty line and bytes beyond a full line are taken and give
//   no result
// reset: clears the fill count, the queue and the output register; the line
//   store itself is not cleared, since only written entries are ever read
// stall: when res.ready is low the output register holds its item, the back
//   end waits, and once the queue fills rx.ready drops
`default_nettype none
module serial_console_line_editor
  import sle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sle_rx_if.sink    rx,
  sle_res_if.source res
);

  // front to queue
  logic              enq_valid;
  cmd_t              enq_cmd;
  logic              q_full;
  // queue to back
  logic              q_valid;
  cmd_t              q_cmd;
  logic              pop;
  // line store ports
  line_wr_t          wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  // back tells front the carriage return has been handled, with any stored line read out
  logic              cr_done;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .q_full    (q_full),
    .cr_done   (cr_done),
    .enq_valid (enq_valid),
    .enq_cmd   (enq_cmd),
    .wr        (wr)
  );

  sle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (enq_valid),
    .in_cmd    (enq_cmd),
    .full      (q_full),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .pop       (pop)
  );

  // line store, one byte per entry
  sle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_SIZE)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .cr_done (cr_done),
    .res     (res)
  );

endmodule
`default_nettype wire

@@ src/sle_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ src/sle_front.sv @@
// front end: accepts received bytes, keeps the fill count, writes the line store
`default_nettype none
module sle_front
  import sle_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  sle_rx_if.sink      rx,
  input  wire logic   q_full,
  input  wire logic   cr_done,
  output      logic   enq_valid,
  output      cmd_t   enq_cmd,
  output      line_wr_t wr
);

  logic [ADDR_W-1:0] fill;
  logic [ADDR_W-1:0] fill_next;
  logic              busy;
  logic              acc;
  logic [7:0]        c;

  assign c        = rx.rx_byte;
  // hold off while a line is being handed over, so the store is not overwritten
  assign rx.ready = !busy && !q_full;
  assign acc      = rx.valid && rx.ready;

  always_comb begin
    enq_valid   = 1'b0;
    enq_cmd.op  = OP_ECHO;
    enq_cmd.data = c;
    enq_cmd.len = fill;
    wr.en       = 1'b0;
    wr.addr     = fill;
    wr.data     = c;
    fill_next   = fill;
    unique case (c)
      CH_LF: begin
      end
      CH_BS: begin
        if (fill != '0) begin
          enq_valid  = acc;
          enq_cmd.op = OP_BS;
          if (acc) fill_next = fill - ADDR_W'(1);
        end
      end
      CH_CR: begin
        enq_valid  = acc;
        enq_cmd.op = OP_CR;
        if (acc) fill_next = '0;
      end
      default: begin
        if (fill < ADDR_W'(LINE_SIZE - 1)) begin
          enq_valid = acc;
          wr.en     = acc;
          if (acc) fill_next = fill + ADDR_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      busy <= 1'b0;
    end else begin
      fill <= fill_next;
      if (acc && c == CH_CR) begin
        busy <= 1'b1;
      end else if (cr_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sle_queue.sv @@
// short command queue between front and back end
`default_nettype none
module sle_queue
  import sle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire cmd_t in_cmd,
  output      logic full,
  output      logic out_valid,
  output      cmd_t out_cmd,
  input  wire logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              take;

  assign full      = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rptr];
  assign push      = in_valid && !full;
  assign take      = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      if (take) rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      if (push && !take) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (take && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sle_back.sv @@
// back end: turns commands into echo, line and empty line result items
`default_nettype none
module sle_back
  import sle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output      logic        pop,
  output      logic [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]  rd_data,
  output      logic        cr_done,
  sle_res_if.source        res
);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cmd;
  logic [1:0]        step;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_inc;
  logic              out_free;
  logic              emit;
  logic [1:0]        emit_kind;
  logic [7:0]        emit_value;
  logic              emit_last;
  logic              fin;
  logic              line_end;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [7:0]        out_value;
  logic              out_last;

  assign out_free  = !out_valid || res.ready;
  assign idx_inc   = idx + ADDR_W'(1);
  assign line_end  = idx_inc == cmd.len;
  assign rd_addr   = idx;
  assign res.valid = out_valid;
  assign res.kind  = out_kind;
  assign res.value = out_value;
  assign res.last  = out_last;

  // item of the current echo step, or the stored byte while the line is read out
  always_comb begin
    emit_kind  = KIND_ECHO;
    emit_value = cmd.data;
    emit_last  = 1'b0;
    fin        = 1'b0;
    unique case (cmd.op)
      OP_ECHO: begin
        emit_last = 1'b1;
        fin       = 1'b1;
      end
      OP_BS: begin
        emit_value = (step == 2'd1) ? CH_SPACE : CH_BS;
        emit_last  = step == 2'd2;
        fin        = step == 2'd2;
      end
      OP_CR: begin
        case (step)
          2'd1: emit_value = CH_LF;
          2'd3: begin
            emit_kind  = KIND_EMPTY;
            emit_value = '0;
            emit_last  = 1'b1;
            fin        = 1'b1;
          end
          default: emit_value = CH_CR;
        endcase
      end
      default: begin
        emit_last = 1'b1;
        fin       = 1'b1;
      end
    endcase
    if (state == BK_LINE) begin
      emit_kind  = KIND_LINE;
      emit_value = rd_data;
      emit_last  = line_end;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_ECHO;
      BK_ECHO: begin
        if (out_free) begin
          if (fin) begin
            state_next = BK_IDLE;
          end else if (cmd.op == OP_CR && step == 2'd2) begin
            state_next = (cmd.len == '0) ? BK_ECHO : BK_RD;
          end
        end
      end
      BK_RD:   state_next = BK_LINE;
      BK_LINE: if (out_free) state_next = line_end ? BK_IDLE : BK_RD;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    emit    = 1'b0;
    cr_done = 1'b0;
    unique case (state)
      BK_IDLE: pop = q_valid;
      BK_ECHO: begin
        emit    = out_free;
        cr_done = out_free && cmd.op == OP_CR && step == 2'd3;
      end
      BK_RD: begin
      end
      BK_LINE: begin
        emit    = out_free;
        cr_done = out_free && line_end;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd  <= q_cmd;
      step <= '0;
      idx  <= '0;
    end else begin
      if (state == BK_ECHO && out_free) step <= step + 2'd1;
      if (state == BK_LINE && out_free) idx <= idx_inc;
    end
    if (emit) begin
      out_kind  <= emit_kind;
      out_value <= emit_value;
      out_last  <= emit_last;
    end
  end

endmodule
`default_nettype wire

@@ src/sle_checker.sv @@
// port level checks for the line editor and their binding
`default_nettype none
module sle_checker
  import sle_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_kind,
  input wire logic [7:0] res_value,
  input wire logic       res_last
);

  // a pending result is not withdrawn
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // only the three kinds are produced
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_kind == KIND_ECHO || res_kind == KIND_LINE ||
                   res_kind == KIND_EMPTY))
    else $error("illegal result kind");

  // empty line marker ends its sequence and carries zero
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_EMPTY |-> res_last && res_value == '0)
    else $error("empty line marker malformed");

endmodule

bind serial_console_line_editor sle_checker u_sle_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.kind),
  .res_value (res.value),
  .res_last  (res.last)
);
`default_nettype wire
